### rtl/zms_pkg.sv
package zms_pkg;

  localparam int unsigned SIZE_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [0:0] {
    ST_LOAD,
    ST_SCAN
  } zms_state_t;

  typedef struct packed {
    logic load_en;
    logic scan_init;
    logic read_en;
  } zms_cmd_t;

  typedef struct packed {
    logic load_last;
    logic scan_last;
    logic out_valid;
  } zms_status_t;

endpackage

### rtl/zigzag_matrix_scan.sv
// The item that completes the matrix moves the controller to its scan state; the first result
// is then registered from the store. Loading takes one item per cycle; the scan then gives
// one result per cycle while out_ready is high.
// Input items are refused while a scan runs; its pace is set by the one read port of the store.
// Reset sets the size to 8 (limited to SIZE_MAX) and clears the load count;
// the element store is not cleared.
module zigzag_matrix_scan #(
  parameter int unsigned SIZE_MAX = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [zms_pkg::DATA_W-1:0] element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [zms_pkg::DATA_W-1:0] out_value,
  output logic                              last_of_scan,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [zms_pkg::SIZE_W-1:0]        matrix_size
);
  import zms_pkg::*;

  zms_cmd_t    cmd;
  zms_status_t status;

  assign cfg_ready = 1'b1;
  assign out_valid = status.out_valid;

  zms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ready)
  );

  zms_datapath #(
    .SIZE_MAX (SIZE_MAX)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_valid && cfg_ready),
    .matrix_size   (matrix_size),
    .element_value (element_value),
    .out_ready     (out_ready),
    .status        (status),
    .out_value     (out_value),
    .last_of_scan  (last_of_scan)
  );

endmodule

### rtl/zms_ctrl.sv
module zms_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 out_ready,
  input  zms_pkg::zms_status_t status,
  output zms_pkg::zms_cmd_t    cmd,
  output logic                 in_ready
);
  import zms_pkg::*;

  zms_state_t state;
  zms_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (in_valid && status.load_last) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((!status.out_valid || out_ready) && status.scan_last) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load_en   = 1'b0;
    cmd.scan_init = 1'b0;
    cmd.read_en   = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready      = 1'b1;
        cmd.load_en   = in_valid;
        cmd.scan_init = in_valid && status.load_last;
      end
      ST_SCAN: begin
        cmd.read_en = !status.out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Loading and scanning never overlap.
  assert property (@(posedge clk) disable iff (rst) cmd.load_en |-> !cmd.read_en)
    else $error("load and read commanded together");

  assert property (@(posedge clk) disable iff (rst) cmd.scan_init |=> state == ST_SCAN)
    else $error("scan did not start after the matrix was complete");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cmd.read_en && !status.scan_last) |=> state == ST_SCAN)
    else $error("scan left before its last item");

endmodule

### rtl/zms_datapath.sv
module zms_datapath #(
  parameter int unsigned SIZE_MAX = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  zms_pkg::zms_cmd_t                 cmd,
  input  logic                              cfg_we,
  input  logic [zms_pkg::SIZE_W-1:0]        matrix_size,
  input  logic signed [zms_pkg::DATA_W-1:0] element_value,
  input  logic                              out_ready,
  output zms_pkg::zms_status_t              status,
  output logic signed [zms_pkg::DATA_W-1:0] out_value,
  output logic                              last_of_scan
);
  import zms_pkg::*;

  localparam int unsigned DEPTH = SIZE_MAX * SIZE_MAX;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (SIZE_MAX > 1) ? $clog2(SIZE_MAX) : 1;
  localparam int unsigned NW    = $clog2(DEPTH + 1);
  localparam int unsigned PW    = AW + SIZE_W;
  localparam logic [SIZE_W-1:0] SIZE_LIM = SIZE_W'(SIZE_MAX);

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [SIZE_W-1:0]   size_sel;
  logic [SIZE_W-1:0]   eff_next;
  logic [2*SIZE_W-1:0] area;
  logic [NW-1:0]       total_m1_next;
  logic [SIZE_W-1:0]   eff_n;
  logic [NW-1:0]       total_m1;
  logic [CW-1:0]       lim;
  logic [CW-1:0]       lim_next;
  logic [NW-1:0]       load_count;
  logic [NW-1:0]       scan_cnt;
  logic [CW-1:0]       row;
  logic [CW-1:0]       col;
  logic [CW-1:0]       row_next;
  logic [CW-1:0]       col_next;
  logic                dir;
  logic                dir_next;
  logic [PW-1:0]       addr_full;
  logic [AW-1:0]       rd_addr;
  logic                out_valid;

  always_comb begin
    size_sel = rst ? SIZE_RESET : matrix_size;
    if (size_sel == '0) begin
      eff_next = SIZE_W'(1);
    end else if (size_sel > SIZE_LIM) begin
      eff_next = SIZE_LIM;
    end else begin
      eff_next = size_sel;
    end
    area          = (2*SIZE_W)'(eff_next) * (2*SIZE_W)'(eff_next);
    total_m1_next = NW'(area - (2*SIZE_W)'(1));
    lim_next      = CW'(eff_next - SIZE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      eff_n      <= eff_next;
      total_m1   <= total_m1_next;
      lim        <= lim_next;
      load_count <= '0;
    end else if (cmd.load_en) begin
      load_count <= status.load_last ? '0 : load_count + NW'(1);
    end
  end

  // Zigzag walk: even diagonals move up and right, odd ones down and left.
  always_comb begin
    row_next = row;
    col_next = col;
    dir_next = dir;
    if (!dir) begin
      if (col == lim) begin
        row_next = row + CW'(1);
        dir_next = 1'b1;
      end else if (row == '0) begin
        col_next = col + CW'(1);
        dir_next = 1'b1;
      end else begin
        row_next = row - CW'(1);
        col_next = col + CW'(1);
      end
    end else begin
      if (row == lim) begin
        col_next = col + CW'(1);
        dir_next = 1'b0;
      end else if (col == '0) begin
        row_next = row + CW'(1);
        dir_next = 1'b0;
      end else begin
        row_next = row + CW'(1);
        col_next = col - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.scan_init) begin
      row      <= '0;
      col      <= '0;
      dir      <= 1'b0;
      scan_cnt <= '0;
    end else if (cmd.read_en) begin
      row      <= row_next;
      col      <= col_next;
      dir      <= dir_next;
      scan_cnt <= scan_cnt + NW'(1);
    end
  end

  assign addr_full = PW'(row) * PW'(eff_n) + PW'(col);
  assign rd_addr   = addr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      mem[load_count[AW-1:0]] <= element_value;
    end
    if (cmd.read_en) begin
      out_value    <= mem[rd_addr];
      last_of_scan <= status.scan_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.read_en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.load_last = (load_count == total_m1);
  assign status.scan_last = (scan_cnt == total_m1);
  assign status.out_valid = out_valid;

  assert property (@(posedge clk) disable iff (rst) load_count <= total_m1)
    else $error("load count ran past the matrix");

  assert property (@(posedge clk) disable iff (rst)
    cmd.scan_init |=> (row == '0 && col == '0 && scan_cnt == '0))
    else $error("scan did not start at the first element");

  assert property (@(posedge clk) disable iff (rst)
    (cmd.read_en && status.scan_last) |=> (out_valid && last_of_scan))
    else $error("final item of the scan not marked");

  assert property (@(posedge clk) disable iff (rst) cmd.read_en |-> addr_full < PW'(DEPTH))
    else $error("scan address outside the store");

endmodule

### tb/sv/testbench.sv
module testbench;
  import zms_pkg::*;

  localparam int unsigned SIZE_MAX = 8;
  localparam int unsigned STORE_DEPTH = SIZE_MAX * SIZE_MAX;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_PAUSE = 8;
  localparam int unsigned RANDOM_ITEMS = 16;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } scan_result_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [DATA_W-1:0] element_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [DATA_W-1:0] out_value;
  logic                     last_of_scan;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [SIZE_W-1:0]        matrix_size;

  logic signed [DATA_W-1:0] matrix_copy [STORE_DEPTH];
  int unsigned              loaded;
  logic [SIZE_W-1:0]        size_reg;
  scan_result_t             zigzag_expected [$];
  scan_result_t             oldest;
  int unsigned              send_idle_pct;
  int unsigned              recv_stall_pct;
  int unsigned              quiet_cycles;
  int                       errors;

  zigzag_matrix_scan #(
    .SIZE_MAX(SIZE_MAX)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .element_value(element_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .last_of_scan (last_of_scan),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .matrix_size  (matrix_size)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned active_size();
    if (size_reg == 0) begin
      return 1;
    end
    if (size_reg > SIZE_MAX) begin
      return SIZE_MAX;
    end
    return 32'(size_reg);
  endfunction

  // Stores one element and, when the matrix is complete, queues its zigzag scan.
  function automatic void load_element(input logic signed [DATA_W-1:0] v);
    int unsigned n;
    int unsigned total;
    int unsigned lo;
    int unsigned hi;
    int unsigned row;
    int unsigned emitted;
    scan_result_t r;
    n = active_size();
    total = n * n;
    if (loaded >= total) begin
      loaded = 0;
    end
    matrix_copy[loaded] = v;
    loaded++;
    if (loaded < total) begin
      return;
    end
    loaded = 0;
    emitted = 0;
    for (int unsigned d = 0; d + 1 < 2 * n; d++) begin
      lo = (d + 1 > n) ? d + 1 - n : 0;
      hi = (d < n - 1) ? d : n - 1;
      for (int unsigned i = 0; i <= hi - lo; i++) begin
        row = (d % 2 == 0) ? hi - i : lo + i;
        r.value = matrix_copy[(row * n + (d - row)) % STORE_DEPTH];
        emitted++;
        r.last = (emitted == total);
        zigzag_expected.push_back(r);
      end
    end
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (zigzag_expected.size() == 0) begin
        $error("unexpected result: out_value %0d last_of_scan %0b", out_value, last_of_scan);
        errors++;
      end else begin
        oldest = zigzag_expected.pop_front();
        if (out_value !== oldest.value) begin
          $error("out_value expected %0d, actual %0d", oldest.value, out_value);
          errors++;
        end
        if (last_of_scan !== oldest.last) begin
          $error("last_of_scan expected %0b, actual %0b", oldest.last, last_of_scan);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic send_element(input logic signed [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (!in_ready);
    load_element(v);
  endtask

  task automatic load_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      send_element($urandom);
    end
  endtask

  task automatic drain_scans();
    in_valid <= 1'b0;
    while (zigzag_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] s);
    drain_scans();
    cfg_valid <= 1'b1;
    matrix_size <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    size_reg = s;
    loaded = 0;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 76;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 76;
      end
      default: begin
        send_idle_pct = 25;
        recv_stall_pct = 25;
      end
    endcase
  endtask

  task automatic test_reset_size();
    load_random(STORE_DEPTH);
  endtask

  task automatic test_single_element();
    write_size(4'd1);
    send_element(32'sh8000_0000);
    send_element(32'sh7fff_ffff);
    send_element(32'sh0000_0000);
    send_element(32'shffff_ffff);
    send_element(32'shaaaa_aaaa);
    send_element(32'sh5555_5555);
  endtask

  task automatic test_odd_size();
    write_size(4'd3);
    for (int unsigned k = 0; k < 9; k++) begin
      send_element(32'(k + 1) * 32'h1111_1111);
    end
  endtask

  task automatic test_size_clamp();
    write_size(4'd0);
    send_element(32'sh1234_5678);
    write_size(4'd15);
    load_random(STORE_DEPTH);
  endtask

  task automatic test_resize_mid_load();
    write_size(4'd3);
    send_element(32'sh0bad_0bad);
    send_element(32'sh0bad_0bad);
    write_size(4'd2);
    for (int unsigned k = 0; k < 4; k++) begin
      send_element(32'sh4000_0000 + 32'(k));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    int unsigned total;
    int unsigned pick;
    logic [SIZE_W-1:0] s;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      s = SIZE_W'($urandom_range(5, 0));
      write_size(s);
      total = active_size() * active_size();
      for (int unsigned rep = $urandom_range(2, 1); rep > 0; rep--) begin
        load_random(total);
        sent += total;
      end
      if (total > 1 && $urandom_range(5) == 0) begin
        pick = $urandom_range(total - 1, 1);
        load_random(pick);
        sent += pick;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    element_value = '0;
    cfg_valid = 1'b0;
    matrix_size = SIZE_RESET;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    errors = 0;
    loaded = 0;
    size_reg = SIZE_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(0);
    test_reset_size();
    set_idling(1);
    test_single_element();
    test_odd_size();
    set_idling(2);
    test_size_clamp();
    set_idling(3);
    test_resize_mid_load();
    test_random_traffic();

    drain_scans();
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
